### rtl/core/double_ended_queue_unit_macros.svh
// assertion shorthands shared by the deque rtl
// every check is clocked on clk and held off while rst is high
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// condition holds at every edge
`define DEQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define DEQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/deq_pkg.sv
`timescale 1ns / 1ps
package deq_pkg;

  // field widths
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  // default ring size
  localparam int unsigned DEQ_DEPTH = 16;

  typedef logic [ACTION_W-1:0]       action_t;
  typedef logic signed [WORD_W-1:0]  word_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [STATUS_W-1:0]       status_t;

  // action codes
  localparam action_t ACT_PUSH_FRONT = 3'd0;
  localparam action_t ACT_PUSH_BACK  = 3'd1;
  localparam action_t ACT_POP_FRONT  = 3'd2;
  localparam action_t ACT_POP_BACK   = 3'd3;
  localparam action_t ACT_READ       = 3'd4;

  // status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;    // capture the incoming transfer
    logic exec;       // pointer, count and ring write update
    logic rd_first;   // read index slot and front slot
    logic rd_second;  // read back slot, capture front and index data
    logic load_out;   // fill the result register
  } deq_cmd_t;

endpackage

### rtl/core/deq_item_if.sv
`timescale 1ns / 1ps
interface deq_item_if import deq_pkg::*; ();
  logic    valid;
  logic    ready;
  action_t action;
  word_t   value_in;
  pos_t    position;

  modport source (output valid, output action, output value_in, output position,
                  input ready);
  modport sink (input valid, input action, input value_in, input position,
                output ready);
endinterface

### rtl/core/deq_result_if.sv
`timescale 1ns / 1ps
interface deq_result_if import deq_pkg::*; ();
  logic    valid;
  logic    ready;
  word_t   read_value;
  word_t   front_value;
  word_t   back_value;
  count_t  entry_count;
  status_t status;

  modport source (output valid, output read_value, output front_value,
                  output back_value, output entry_count, output status, input ready);
  modport sink (input valid, input read_value, input front_value,
                input back_value, input entry_count, input status, output ready);
endinterface

### rtl/core/deq_datapath.sv
`timescale 1ns / 1ps
`include "double_ended_queue_unit_macros.svh"
module deq_datapath import deq_pkg::*; #(
  parameter int unsigned DEPTH = DEQ_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  deq_cmd_t cmd,
  input  action_t  action,
  input  word_t    value_in,
  input  pos_t     position,
  output word_t    read_value,
  output word_t    front_value,
  output word_t    back_value,
  output count_t   entry_count,
  output status_t  status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  // ring slot of head plus an offset below DEPTH
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [PTR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (PTR_W + 1)'(DEPTH)) begin
      sum = sum - (PTR_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // captured transfer
  action_t act_q;
  word_t   val_q;
  pos_t    pos_q;

  // queue state
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  status_t          st_q;
  status_t          st_next;

  // ring memory and its read registers
  word_t mem [DEPTH];
  word_t rdata_a;
  word_t rdata_b;
  word_t readv_q;
  word_t front_q;

  logic             full;
  logic             empty;
  logic             is_push;
  logic             is_pop;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] head_dec;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] addr_a;
  logic [PTR_W-1:0] addr_b;
  logic [CNT_W-1:0] count_m1;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             pos_beyond;
  logic [EXT_W-1:0] cnt_wide;

  assign full       = (count == FULL_CNT);
  assign empty      = (count == '0);
  assign is_push    = (act_q == ACT_PUSH_FRONT) || (act_q == ACT_PUSH_BACK);
  assign is_pop     = (act_q == ACT_POP_FRONT) || (act_q == ACT_POP_BACK);
  assign head_dec   = (head == '0) ? LAST_SLOT : head - PTR_W'(1);
  assign head_inc   = (head == LAST_SLOT) ? '0 : head + PTR_W'(1);
  assign count_m1   = count - CNT_W'(1);
  assign pos_ext    = CMP_W'(pos_q);
  assign cnt_ext    = CMP_W'(count);
  assign pos_beyond = (pos_ext >= cnt_ext);

  // step decode: only head, count and one slot change
  always_comb begin
    head_next  = head;
    count_next = count;
    st_next    = ST_OK;
    wr_en      = 1'b0;
    wr_addr    = wrap_add(head, count[PTR_W-1:0]);
    unique case (act_q)
      ACT_PUSH_FRONT: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          head_next  = head_dec;
          count_next = count + CNT_W'(1);
          wr_en      = 1'b1;
          wr_addr    = head_dec;
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
          wr_en      = 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          head_next  = head_inc;
          count_next = count_m1;
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          count_next = count_m1;
        end
      end
      ACT_READ: begin
        if (pos_beyond) begin
          st_next = ST_RANGE;
        end
      end
      default: begin
        st_next = ST_OK;
      end
    endcase
  end

  // index slot on port a; front then back slot on port b
  assign addr_a = wrap_add(head, pos_ext[PTR_W-1:0]);
  assign addr_b = cmd.rd_first ? head : wrap_add(head, count_m1[PTR_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_q <= action;
      val_q <= value_in;
      pos_q <= position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      st_q <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= val_q;
    end
    if (cmd.rd_first) begin
      rdata_a <= mem[addr_a];
    end
    if (cmd.rd_first || cmd.rd_second) begin
      rdata_b <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_second) begin
      readv_q <= ((act_q == ACT_READ) && (st_q == ST_OK)) ? rdata_a : '0;
      front_q <= empty ? '0 : rdata_b;
    end
  end

  assign cnt_wide = EXT_W'(count);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_value  <= readv_q;
      front_value <= front_q;
      back_value  <= empty ? '0 : rdata_b;
      entry_count <= cnt_wide[COUNT_W-1:0];
      status      <= st_q;
    end
  end

  `DEQ_ASSERT_ALWAYS(DP_COUNT_BOUND, count <= FULL_CNT, "count above ring depth")
  `DEQ_ASSERT_NEXT(DP_FULL_PUSH_HOLDS, cmd.exec && is_push && full,
                   $stable(count) && $stable(head), "push into full ring changed state")
  `DEQ_ASSERT_NEXT(DP_POP_DECREMENTS, cmd.exec && is_pop && !empty,
                   count == $past(count) - CNT_W'(1), "pop did not drop count by one")

endmodule

### rtl/core/deq_controller.sv
`timescale 1ns / 1ps
`include "double_ended_queue_unit_macros.svh"
module deq_controller import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output deq_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_RD1  = 5'b00100,
    S_RD2  = 5'b01000,
    S_LOAD = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd_first = 1'b1;
        state_next   = S_RD2;
      end
      S_RD2: begin
        cmd.rd_second = 1'b1;
        state_next    = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `DEQ_ASSERT_SAME(CTL_LOAD_WHEN_FREE, cmd.load_out, !out_valid || out_ready, "result register overwritten")
  `DEQ_ASSERT_NEXT(CTL_ACCEPT_EXEC, in_valid && in_ready, cmd.exec, "accepted item not executed")
  `DEQ_ASSERT_NEXT(CTL_LOAD_SHOWS, cmd.load_out, out_valid, "loaded result not presented")

endmodule

### rtl/core/double_ended_queue_unit.sv
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit words held in a ring of DEPTH
// entries (the reported count is 5 bits wide, so at most 31) with a head
// pointer and an entry count. Each item on the items channel pushes front or
// back, pops front or back, or reads the entry at a position counted from the
// front; each gives exactly one transfer on the results channel with the read
// value, the front and back values and the count after the step, and a status
// (ok, empty, full, out of range). A failing pop or read and a push into a
// full ring leave the state alone. A one-hot controller steps through capture,
// update (pointer, count and one ring write), then two reads of the two-port
// ring memory, index and front slot first, back slot second, and finally the
// result register load. The next item is taken as soon as the controller is
// back in idle, even while the previous result still waits in the result
// register, but a new item is taken only after the last one's result has been
// loaded; a result that is not taken holds the controller in the load step of
// the next item. Ring entries have no reset and no clearing pass; only entries
// below the count ever reach the results.
module double_ended_queue_unit import deq_pkg::*; #(
  parameter int unsigned DEPTH = DEQ_DEPTH
) (
  input logic           clk,
  input logic           rst,
  deq_item_if.sink      items,
  deq_result_if.source  results
);

  deq_cmd_t cmd;

  // sequencing and handshakes
  deq_controller u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd)
  );

  // ring memory, pointers and result register
  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .action      (items.action),
    .value_in    (items.value_in),
    .position    (items.position),
    .read_value  (results.read_value),
    .front_value (results.front_value),
    .back_value  (results.back_value),
    .entry_count (results.entry_count),
    .status      (results.status)
  );

endmodule
